// ----- hdl/ett_pkg.sv -----
// ----------------------------------------------------------------------------
// ett_pkg: shared types and tables of the encoder tone tuner
// Position and value widths, the note and cent factor tables, and the
// classified command that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ett_pkg;

   localparam int CountWidth = 32;
   localparam int PosWidth   = 30;
   localparam int NoteWidth  = 7;
   localparam int LevelWidth = 9;
   localparam int CentWidth  = 7;
   localparam int FreqWidth  = 29;
   localparam int DivWidth   = 24;
   localparam int ClockWidth = 28;
   localparam int FactWidth  = 17;

   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_NOTE  = 2'd1;
   localparam logic [1:0] EV_LEVEL = 2'd2;
   localparam logic [1:0] EV_CENT  = 2'd3;

   localparam logic [NoteWidth-1:0]  NoteReset  = 7'd69;
   localparam logic [LevelWidth-1:0] LevelMax   = 9'd256;
   localparam logic [FreqWidth-1:0]  FreqMax    = '1;
   localparam logic [DivWidth-1:0]   DivMin     = 24'd256;
   localparam logic [DivWidth-1:0]   DivMax     = '1;

   // classified poll: which encoder applies and by how much
   typedef struct packed {
      logic [1:0]          event_code;
      logic signed [PosWidth:0] delta;
   } cmd_type;

   // semitone ratios 2^(r/12) in Q1.16
   function automatic logic [16:0] semitone_q16(input logic [3:0] r);
      logic [16:0] v;
      case (r)
         4'd0: v = 17'd65536;   4'd1: v = 17'd69433;   4'd2: v = 17'd73562;
         4'd3: v = 17'd77936;   4'd4: v = 17'd82570;   4'd5: v = 17'd87480;
         4'd6: v = 17'd92682;   4'd7: v = 17'd98193;   4'd8: v = 17'd104031;
         4'd9: v = 17'd110218;  4'd10: v = 17'd116772; default: v = 17'd123715;
      endcase
      return v;
   endfunction

   // note frequency in Q13.16, octave and semitone found by repeated subtraction
   function automatic logic [FreqWidth-1:0] tone_freq_q16(input int m);
      int q;
      int r;
      int sh;
      logic [63:0] v;
      r = m - 69 + 120;
      q = -10;
      for (int k = 0; k < 16; k++) begin
         if (r >= 12) begin
            r = r - 12;
            q = q + 1;
         end
      end
      sh = 16 - q;
      v  = 64'd28835840 * 64'(semitone_q16(4'(r)));
      v  = (v + (64'd1 << (sh - 1))) >> sh;
      return (v > 64'(FreqMax)) ? FreqMax : v[FreqWidth-1:0];
   endfunction

   // cent factor 2^(c/1200) in Q1.16 by truncated series
   // cubic term divided by 6 and quartic by 24 through reciprocal products,
   // exact for the magnitudes that occur here
   function automatic logic [FactWidth-1:0] cent_factor(input int c);
      longint x;
      longint ax;
      longint x2;
      longint p3;
      longint p4;
      longint e;
      x  = longint'(c) * 64'sd620218;
      ax = (x < 0) ? -x : x;
      x2 = (x * x) >>> 30;
      p3 = (x2 * ax) >>> 30;
      p3 = (p3 * 64'sd43691) >>> 18;
      if (x < 0) p3 = -p3;
      p4 = ((x2 * x2) >>> 30) >>> 3;
      p4 = (p4 * 64'sd43691) >>> 17;
      e  = (64'sd1 <<< 30) + x + (x2 >>> 1) + p3 + p4;
      return FactWidth'((e + 64'sd8192) >>> 14);
   endfunction

endpackage

// ----- hdl/ett_if.sv -----
// ----------------------------------------------------------------------------
// ett channel interfaces
// Valid/ready channels for polls, results and the clock register write.
// ----------------------------------------------------------------------------
interface ett_req_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  tone_enc_count;
   logic signed [31:0]  level_enc_count;
   logic signed [31:0]  cent_enc_count;
   modport source (output valid, tone_enc_count, level_enc_count, cent_enc_count,
                   input ready);
   modport sink   (input valid, tone_enc_count, level_enc_count, cent_enc_count,
                   output ready);
endinterface

interface ett_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         event_code;
   logic [6:0]         note_number;
   logic [8:0]         level;
   logic signed [6:0]  cents;
   logic [28:0]        freq_q16;
   logic [23:0]        clock_divider_q8;
   modport source (output valid, event_code, note_number, level, cents, freq_q16,
                   clock_divider_q8, input ready);
   modport sink   (input valid, event_code, note_number, level, cents, freq_q16,
                   clock_divider_q8, output ready);
endinterface

interface ett_csr_if;
   logic        valid;
   logic        ready;
   logic [27:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- hdl/ett_front.sv -----
// ----------------------------------------------------------------------------
// ett_front: poll classifier
// Converts counts to detent positions, keeps the previous positions and
// picks the highest-numbered encoder that moved with its signed delta.
// ----------------------------------------------------------------------------
module ett_front (
   input  logic                       clock,
   input  logic                       reset,
   ett_req_if.sink                    req,
   output logic                       cmd_valid,
   input  logic                       cmd_ready,
   output ett_pkg::cmd_type           cmd
);
   import ett_pkg::*;

   logic [PosWidth-1:0] prev_ff [3];
   logic [PosWidth-1:0] prev_in [3];
   logic [PosWidth-1:0] np [3];
   logic                moved [3];
   logic [1:0]          sel;
   logic [PosWidth-1:0] sel_new, sel_old;

   assign np[0] = req.tone_enc_count[CountWidth-1:2];
   assign np[1] = req.level_enc_count[CountWidth-1:2];
   assign np[2] = req.cent_enc_count[CountWidth-1:2];

   assign req.ready = cmd_ready;
   assign cmd_valid = req.valid;

   // choose the highest-numbered encoder that moved
   always_comb begin
      sel     = EV_NONE;
      sel_new = '0;
      sel_old = '0;
      for (int k = 0; k < 3; k++) begin
         moved[k]   = np[k] != prev_ff[k];
         prev_in[k] = np[k];
         if (moved[k]) begin
            sel     = 2'(k + 1);
            sel_new = np[k];
            sel_old = prev_ff[k];
         end
      end
      cmd.event_code = sel;
      cmd.delta = $signed({sel_new[PosWidth-1], sel_new})
                - $signed({sel_old[PosWidth-1], sel_old});
   end

   // position history
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) prev_ff[k] <= '0;
      end else if (req.valid && req.ready) begin
         prev_ff <= prev_in;
      end
   end

endmodule

// ----- hdl/ett_fifo.sv -----
// ----------------------------------------------------------------------------
// ett_fifo: command queue
// Two-entry queue that decouples the classifier from the back end.
// ----------------------------------------------------------------------------
module ett_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  ett_pkg::cmd_type     in_cmd,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ett_pkg::cmd_type     out_cmd
);
   import ett_pkg::*;

   cmd_type    mem_ff [2];
   logic       wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_cmd   = mem_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer update
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_cmd;
   end

endmodule

// ----- hdl/ett_back.sv -----
// ----------------------------------------------------------------------------
// ett_back: value update and tone arithmetic
// Applies the step with wraparound, looks up the tables, multiplies and runs
// a restoring divider for the sample clock divider.
// ----------------------------------------------------------------------------
module ett_back #(
   parameter int SAMPLES_PER_PERIOD = 125,
   parameter int NOTE_LOW           = 21,
   parameter int NOTE_HIGH          = 108,
   parameter int CENT_SPAN          = 50
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   output logic                       cmd_ready,
   input  ett_pkg::cmd_type           cmd,
   input  logic [ett_pkg::ClockWidth-1:0] sys_clock_hz,
   ett_rsp_if.source                  rsp
);
   import ett_pkg::*;

   localparam int NoteCount = NOTE_HIGH - NOTE_LOW + 1;
   localparam int CentCount = 2 * CENT_SPAN + 1;
   localparam int NumW  = ClockWidth + 24;   // dividend width
   localparam int DenW  = FreqWidth + 11;    // samples * freq
   localparam int CntW  = $clog2(NumW + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOOK = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [NoteWidth-1:0]         note_ff, note_in;
   logic [LevelWidth-1:0]        level_ff, level_in;
   logic signed [CentWidth-1:0]  cent_ff, cent_in;
   logic [1:0]                   ev_ff, ev_in;
   logic [FreqWidth-1:0]         nf_ff, nf_in;
   logic [FactWidth-1:0]         cf_ff, cf_in;
   logic [FreqWidth-1:0]         freq_ff, freq_in;
   logic [DenW-1:0]              den_ff, den_in;
   logic [NumW-1:0]              quo_ff, quo_in;
   logic [DenW:0]                rem_ff, rem_in;
   logic [CntW-1:0]              cnt_ff, cnt_in;
   logic [DivWidth-1:0]          div_ff, div_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic signed [PosWidth+2:0]   sum;
   logic [46:0]                  prod;
   logic [DenW:0]                trial;
   int                           nidx, cidx;

   logic [FreqWidth-1:0]         note_rom [NoteCount];
   logic [FactWidth-1:0]         cent_rom [CentCount];

   // constant tables, evaluated at elaboration
   for (genvar i = 0; i < NoteCount; i++) begin : g_note_rom
      localparam logic [FreqWidth-1:0] Entry = tone_freq_q16(NOTE_LOW + i);
      assign note_rom[i] = Entry;
   end
   for (genvar i = 0; i < CentCount; i++) begin : g_cent_rom
      localparam logic [FactWidth-1:0] Entry = cent_factor(i - CENT_SPAN);
      assign cent_rom[i] = Entry;
   end

   assign cmd_ready   = state_ff == ST_IDLE && !rsp_valid_ff;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.event_code = ev_ff;
   assign rsp.note_number = note_ff;
   assign rsp.level   = level_ff;
   assign rsp.cents   = cent_ff;
   assign rsp.freq_q16 = freq_ff;
   assign rsp.clock_divider_q8 = div_ff;

   always_comb begin
      state_in = state_ff;
      note_in = note_ff; level_in = level_ff; cent_in = cent_ff; ev_in = ev_ff;
      nf_in = nf_ff; cf_in = cf_ff; freq_in = freq_ff; den_in = den_ff;
      quo_in = quo_ff; rem_in = rem_ff; cnt_in = cnt_ff; div_in = div_ff;
      rsp_valid_in = rsp_valid_ff;
      sum = '0;
      prod = '0;
      trial = '0;
      nidx = int'(note_ff) - NOTE_LOW;
      cidx = int'(cent_ff) + CENT_SPAN;
      if (rsp.valid && rsp.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         // apply one step with wraparound
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               ev_in = cmd.event_code;
               case (cmd.event_code)
                  EV_NOTE: begin
                     sum = (PosWidth+3)'(signed'({1'b0, note_ff})) + (PosWidth+3)'(cmd.delta);
                     if (sum < NOTE_LOW)       note_in = NoteWidth'(NOTE_HIGH);
                     else if (sum > NOTE_HIGH) note_in = NoteWidth'(NOTE_LOW);
                     else                      note_in = sum[NoteWidth-1:0];
                  end
                  EV_LEVEL: begin
                     sum = (PosWidth+3)'(signed'({1'b0, level_ff})) + (PosWidth+3)'(cmd.delta);
                     if (sum < 0)         level_in = LevelMax;
                     else if (sum > 256)  level_in = '0;
                     else                 level_in = sum[LevelWidth-1:0];
                  end
                  EV_CENT: begin
                     sum = (PosWidth+3)'(cent_ff) + (PosWidth+3)'(cmd.delta);
                     if (sum < -CENT_SPAN)     cent_in = CentWidth'(CENT_SPAN);
                     else if (sum > CENT_SPAN) cent_in = CentWidth'(-CENT_SPAN);
                     else                      cent_in = sum[CentWidth-1:0];
                  end
                  default: ;
               endcase
               state_in = ST_LOOK;
            end
         end
         // table lookup
         ST_LOOK: begin
            nf_in = '0;
            cf_in = FactWidth'(65536);
            for (int i = 0; i < NoteCount; i++)
               if (nidx == i) nf_in = note_rom[i];
            for (int i = 0; i < CentCount; i++)
               if (cidx == i) cf_in = cent_rom[i];
            state_in = ST_MUL;
         end
         // frequency product and denominator
         ST_MUL: begin
            prod = 47'(nf_ff) * 47'(cf_ff) + 47'd32768;
            freq_in = (prod[46:16] > 31'(FreqMax)) ? FreqMax : prod[16 +: FreqWidth];
            den_in = DenW'(SAMPLES_PER_PERIOD) * DenW'(freq_in);
            quo_in = {sys_clock_hz, 24'd0};
            rem_in = '0;
            cnt_in = CntW'(NumW);
            state_in = ST_DIV;
         end
         // restoring division, one quotient bit a cycle
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               trial = {rem_ff[DenW-1:0], quo_ff[NumW-1]};
               quo_in = {quo_ff[NumW-2:0], 1'b0};
               if (trial >= {1'b0, den_ff}) begin
                  rem_in = trial - {1'b0, den_ff};
                  quo_in[0] = 1'b1;
               end else begin
                  rem_in = trial;
               end
               cnt_in = cnt_ff - CntW'(1);
            end
         end
         // clamp and present
         ST_OUT: begin
            if (den_ff == '0)                       div_in = DivMax;
            else if (quo_ff < NumW'(DivMin))        div_in = DivMin;
            else if (quo_ff > NumW'(DivMax))        div_in = DivMax;
            else                                    div_in = quo_ff[DivWidth-1:0];
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         note_ff <= NoteReset;
         level_ff <= '0;
         cent_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         note_ff <= note_in;
         level_ff <= level_in;
         cent_ff <= cent_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff <= ev_in; nf_ff <= nf_in; cf_ff <= cf_in; freq_ff <= freq_in;
      den_ff <= den_in; quo_ff <= quo_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
      div_ff <= div_in;
   end

endmodule

// ----- hdl/encoder_tone_tuner.sv -----
// ----------------------------------------------------------------------------
// encoder_tone_tuner: three-encoder tone tuner
//
//   channel | direction | payload
//   req     | in        | three raw quadrature counts
//   rsp     | out       | event, note, level, cents, freq, divider
//   csr     | in        | system clock in Hz
//
// An accepted poll passes through the queue, then the step, lookup and multiply
// states, a restoring division (52 quotient bits and a closing check) and a
// clamp before its result can be taken. The back end takes no new poll until
// it has finished the last one and its held result has drained; the classifier
// fills a two-entry queue meanwhile. Reset is synchronous, active high; the clock
// register resets to 125 MHz.
// ----------------------------------------------------------------------------
module encoder_tone_tuner #(
   parameter int SAMPLES_PER_PERIOD = 125,
   parameter int NOTE_LOW           = 21,
   parameter int NOTE_HIGH          = 108,
   parameter int CENT_SPAN          = 50
) (
   input  logic       clock,
   input  logic       reset,
   ett_req_if.sink    req,
   ett_rsp_if.source  rsp,
   ett_csr_if.sink    csr
);
   import ett_pkg::*;

   logic                  f_valid, f_ready, b_valid, b_ready;
   cmd_type               f_cmd, b_cmd;
   logic [ClockWidth-1:0] clk_hz_ff;

   // clock register
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) clk_hz_ff <= ClockWidth'(125000000);
      else if (csr.valid) clk_hz_ff <= csr.data;
   end

   ett_front u_front (.clock, .reset, .req, .cmd_valid(f_valid),
      .cmd_ready(f_ready), .cmd(f_cmd));

   ett_fifo u_fifo (.clock, .reset, .in_valid(f_valid), .in_ready(f_ready),
      .in_cmd(f_cmd), .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd));

   ett_back #(.SAMPLES_PER_PERIOD(SAMPLES_PER_PERIOD), .NOTE_LOW(NOTE_LOW),
      .NOTE_HIGH(NOTE_HIGH), .CENT_SPAN(CENT_SPAN)) u_back (.clock, .reset,
      .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
      .sys_clock_hz(clk_hz_ff), .rsp);

endmodule
